[src/ccmap_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cover-crop coordinate mapper package
// Field widths, request and response types, register map and sequencer states.
// ----------------------------------------------------------------------------
package ccmap_pkg;

	localparam int SCREEN_BITS = 13;
	localparam int SOURCE_BITS = 14;
	// screen coordinate times used extent
	localparam int PROD_BITS   = SCREEN_BITS + SOURCE_BITS;
	// reciprocal 2^PROD_BITS / screen dimension needs one more bit
	localparam int RECIP_BITS  = PROD_BITS + 1;
	localparam int ADDR_BITS   = 4;

	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_SOURCE_WIDTH  = 2'd0;
	localparam reg_idx_t REG_SOURCE_HEIGHT = 2'd1;
	localparam reg_idx_t REG_SCREEN_WIDTH  = 2'd2;
	localparam reg_idx_t REG_SCREEN_HEIGHT = 2'd3;

	typedef struct packed {
		logic [SCREEN_BITS-1:0] screen_x;
		logic [SCREEN_BITS-1:0] screen_y;
	} in_req_t;

	typedef struct packed {
		logic [SOURCE_BITS-1:0] source_x;
		logic [SOURCE_BITS-1:0] source_y;
		logic                   out_of_range;
	} out_rsp_t;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_CMP   = 6'b000010,
		ST_DIVU  = 6'b000100,
		ST_FIX   = 6'b001000,
		ST_DIVRW = 6'b010000,
		ST_DIVRH = 6'b100000
	} seq_state_t;

endpackage

[src/cover_crop_coordinate_mapper_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cover-crop coordinate mapper
// Maps a screen pixel to the source pixel it samples when the picture is
// scaled to cover the screen with its aspect kept and cropped to center.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | request   | in_valid / in_ready    | in_data  (screen_x, screen_y)
//  out     | response  | out_valid / out_ready  | out_data (source_x, source_y,
//          |           |                        |           out_of_range)
//  cfg     | APB write | psel, penable, pwrite  | paddr, pwdata (prdata readback)
//
//  One request per cycle, unless held, through a four-stage pipeline.
//  After reset and after every register write a setup sequencer runs
//  (one shared serial divider, one quotient bit per cycle) with in_ready
//  low; it derives crop extents, offsets and the two screen reciprocals.
//  A stalled output freezes all stages together.
// ----------------------------------------------------------------------------
module cover_crop_coordinate_mapper_top
	import ccmap_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_req_t              in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_rsp_t             out_data,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam int CNT_BITS = $clog2(RECIP_BITS);

	// configuration registers
	logic [SOURCE_BITS-1:0] src_w_q, src_h_q;
	logic [SCREEN_BITS-1:0] scr_w_q, scr_h_q;

	// derived setup values
	logic [SOURCE_BITS-1:0] used_w_q, used_h_q, off_x_q, off_y_q;
	logic [RECIP_BITS-1:0]  rw_q, rh_q;
	logic                   wide_q;
	seq_state_t             seq_q;

	// serial divider
	logic [RECIP_BITS-1:0]  div_num_q;
	logic [SCREEN_BITS-1:0] div_den_q, div_rem_q;
	logic [CNT_BITS-1:0]    div_cnt_q;
	logic [SCREEN_BITS:0]   div_trial;
	logic                   div_ge;
	logic [SCREEN_BITS-1:0] div_rem_nx;
	logic [RECIP_BITS-1:0]  div_quo;
	logic                   div_last;

	logic                   cfg_wr;
	reg_idx_t               cfg_idx;
	logic [PROD_BITS-1:0]   cross_a, cross_b;
	logic [SOURCE_BITS-1:0] fix_w, fix_h;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		case (cfg_idx)
			REG_SOURCE_WIDTH:  prdata = {{(32-SOURCE_BITS){1'b0}}, src_w_q};
			REG_SOURCE_HEIGHT: prdata = {{(32-SOURCE_BITS){1'b0}}, src_h_q};
			REG_SCREEN_WIDTH:  prdata = {{(32-SCREEN_BITS){1'b0}}, scr_w_q};
			REG_SCREEN_HEIGHT: prdata = {{(32-SCREEN_BITS){1'b0}}, scr_h_q};
			default:           prdata = '0;
		endcase
	end

	// one restoring step: shift the next dividend bit into the remainder
	assign div_trial  = {div_rem_q, div_num_q[RECIP_BITS-1]};
	assign div_ge     = div_trial >= {1'b0, div_den_q};
	assign div_rem_nx = div_ge ? SCREEN_BITS'(div_trial - {1'b0, div_den_q})
	                           : div_trial[SCREEN_BITS-1:0];
	assign div_quo    = {div_num_q[RECIP_BITS-2:0], div_ge};
	assign div_last   = div_cnt_q == CNT_BITS'(RECIP_BITS - 1);

	// crop decision: source_width*screen_height vs source_height*screen_width
	assign cross_a = PROD_BITS'(src_w_q * scr_h_q);
	assign cross_b = PROD_BITS'(src_h_q * scr_w_q);

	// zero extent falls back to the whole picture
	assign fix_w = (used_w_q == '0 || used_h_q == '0) ? src_w_q : used_w_q;
	assign fix_h = (used_w_q == '0 || used_h_q == '0) ? src_h_q : used_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= SOURCE_BITS'(1);
			src_h_q <= SOURCE_BITS'(1);
			scr_w_q <= SCREEN_BITS'(1);
			scr_h_q <= SCREEN_BITS'(1);
			seq_q   <= ST_CMP;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_SOURCE_WIDTH:  src_w_q <= pwdata[SOURCE_BITS-1:0];
				REG_SOURCE_HEIGHT: src_h_q <= pwdata[SOURCE_BITS-1:0];
				REG_SCREEN_WIDTH:  scr_w_q <= pwdata[SCREEN_BITS-1:0];
				REG_SCREEN_HEIGHT: scr_h_q <= pwdata[SCREEN_BITS-1:0];
				default: ;
			endcase
			seq_q <= ST_CMP;
		end else begin
			unique case (seq_q)
				ST_IDLE: ;
				ST_CMP:  seq_q <= ST_DIVU;
				ST_DIVU: if (div_last) seq_q <= ST_FIX;
				ST_FIX:  seq_q <= ST_DIVRW;
				ST_DIVRW: if (div_last) seq_q <= ST_DIVRH;
				ST_DIVRH: if (div_last) seq_q <= ST_IDLE;
				default: seq_q <= ST_IDLE;
			endcase
		end
	end

	// setup datapath: no reset, the sequencer rebuilds it after reset
	always_ff @(posedge clk) begin
		unique case (seq_q)
			ST_CMP: begin
				wide_q    <= cross_a > cross_b;
				div_rem_q <= '0;
				div_cnt_q <= '0;
				if (cross_a > cross_b) begin
					div_num_q <= RECIP_BITS'(cross_b);
					div_den_q <= scr_h_q;
				end else begin
					div_num_q <= RECIP_BITS'(cross_a);
					div_den_q <= scr_w_q;
				end
			end
			ST_FIX: begin
				used_w_q  <= fix_w;
				used_h_q  <= fix_h;
				off_x_q   <= SOURCE_BITS'((src_w_q - fix_w) >> 1);
				off_y_q   <= SOURCE_BITS'((src_h_q - fix_h) >> 1);
				div_num_q <= RECIP_BITS'(1) << PROD_BITS;
				div_den_q <= scr_w_q;
				div_rem_q <= '0;
				div_cnt_q <= '0;
			end
			ST_DIVU, ST_DIVRW, ST_DIVRH: begin
				if (!div_last) begin
					div_num_q <= div_quo;
					div_rem_q <= div_rem_nx;
					div_cnt_q <= div_cnt_q + CNT_BITS'(1);
				end else begin
					div_rem_q <= '0;
					div_cnt_q <= '0;
					if (seq_q == ST_DIVU) begin
						if (wide_q) begin
							used_w_q <= div_quo[SOURCE_BITS-1:0];
							used_h_q <= src_h_q;
						end else begin
							used_w_q <= src_w_q;
							used_h_q <= div_quo[SOURCE_BITS-1:0];
						end
					end else if (seq_q == ST_DIVRW) begin
						rw_q      <= div_quo;
						div_num_q <= RECIP_BITS'(1) << PROD_BITS;
						div_den_q <= scr_h_q;
					end else begin
						rh_q <= div_quo;
					end
				end
			end
			default: ;
		endcase
	end

	// ---------------- mapping pipeline ----------------
	logic advance;
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic oor_s1, oor_s2, oor_s3;
	logic [PROD_BITS-1:0]  nx_s1, ny_s1, nx_s2, ny_s2, nx_s3, ny_s3;
	logic [PROD_BITS+RECIP_BITS-1:0] px_s2, py_s2;
	logic [SOURCE_BITS-1:0] qx_s3, qy_s3;
	logic [PROD_BITS-1:0]  mx_s3, my_s3;
	logic [SOURCE_BITS-1:0] qx_est, qy_est;
	logic [PROD_BITS-1:0]  rx, ry;
	logic                  accept;
	out_rsp_t              rsp_s4;

	// whole pipe moves when the output register is free or being emptied
	assign advance  = !vld_s4 || out_ready;
	assign in_ready = (seq_q == ST_IDLE) && advance;
	assign accept   = in_valid && in_ready;

	// estimate floor(N/D) from the reciprocal; it can fall one short
	assign qx_est = px_s2[PROD_BITS +: SOURCE_BITS];
	assign qy_est = py_s2[PROD_BITS +: SOURCE_BITS];
	assign rx     = nx_s3 - mx_s3;
	assign ry     = ny_s3 - my_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			// stage 1: range check, coordinate times used extent
			oor_s1 <= in_data.screen_x >= scr_w_q || in_data.screen_y >= scr_h_q;
			nx_s1  <= PROD_BITS'(in_data.screen_x * used_w_q);
			ny_s1  <= PROD_BITS'(in_data.screen_y * used_h_q);
			// stage 2: multiply by reciprocal
			oor_s2 <= oor_s1;
			nx_s2  <= nx_s1;
			ny_s2  <= ny_s1;
			px_s2  <= nx_s1 * rw_q;
			py_s2  <= ny_s1 * rh_q;
			// stage 3: back-multiply the estimate
			oor_s3 <= oor_s2;
			nx_s3  <= nx_s2;
			ny_s3  <= ny_s2;
			qx_s3  <= qx_est;
			qy_s3  <= qy_est;
			mx_s3  <= PROD_BITS'(qx_est * scr_w_q);
			my_s3  <= PROD_BITS'(qy_est * scr_h_q);
			// stage 4: correct by one, add crop offset, zero outside screen
			if (oor_s3) begin
				rsp_s4.source_x <= '0;
				rsp_s4.source_y <= '0;
			end else begin
				rsp_s4.source_x <= SOURCE_BITS'(off_x_q + qx_s3
					+ SOURCE_BITS'(rx >= PROD_BITS'(scr_w_q)));
				rsp_s4.source_y <= SOURCE_BITS'(off_y_q + qy_s3
					+ SOURCE_BITS'(ry >= PROD_BITS'(scr_h_q)));
			end
			rsp_s4.out_of_range <= oor_s3;
		end
	end

	assign out_valid = vld_s4;
	assign out_data  = rsp_s4;

	// ---------------- assertions ----------------
	a_cfg_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> !in_ready)
		else $error("request taken right after a register write");

	a_setup_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q != ST_IDLE) |-> !in_ready)
		else $error("request taken while setup runs");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.out_of_range |->
		out_data.source_x == '0 && out_data.source_y == '0)
		else $error("out of range response with nonzero coordinates");

	a_x_inside: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.out_of_range && src_w_q != '0 |->
		out_data.source_x < src_w_q)
		else $error("source column beyond picture");

	a_y_inside: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.out_of_range && src_h_q != '0 |->
		out_data.source_y < src_h_q)
		else $error("source row beyond picture");

endmodule
